// ===== sv/nfgc_pkg.sv =====
// ----------------------------------------------------------------------------
// nfgc_pkg
// Shared types and constants for the nearest free grid cell search block.
// ----------------------------------------------------------------------------
package nfgc_pkg;

    // field widths
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 2 * DIM_W + 1;

    // occupancy codes
    localparam logic signed [7:0] CELL_UNKNOWN  = -8'sd1;
    localparam logic signed [7:0] CELL_OCCUPIED = 8'sd100;
    localparam logic signed [7:0] CELL_FREE     = 8'sd0;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_REACHABLE    = 2'd0;
    localparam logic [1:0] ST_RELOCATED    = 2'd1;
    localparam logic [1:0] ST_NO_FREE      = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    typedef logic signed [7:0] cell_t;

    typedef struct packed {
        logic                 req_type;
        logic [INDEX_W-1:0]   cell_index;
        cell_t                cell_value;
        logic [COORD_W-1:0]   target_col;
        logic [COORD_W-1:0]   target_row;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0]   result_col;
        logic [COORD_W-1:0]   result_row;
        logic [1:0]           status;
    } rsp_t;

    // control from the sequencer to the distance unit
    typedef struct packed {
        logic                 clear;
        logic                 sample;
        logic [DIM_W-1:0]     row;
        logic [DIM_W-1:0]     col;
    } dist_ctl_t;

    // best candidate held by the distance unit
    typedef struct packed {
        logic                 found;
        logic [DIM_W-1:0]     row;
        logic [DIM_W-1:0]     col;
    } dist_res_t;

endpackage

// ===== sv/nearest_free_grid_cell_top.sv =====
// ----------------------------------------------------------------------------
// nearest_free_grid_cell_top
// Occupancy grid with nearest free cell search, one cell read per cycle.
// ----------------------------------------------------------------------------
// cell write: the block is ready again at once
// query out of range: goes straight to S_DONE, which registers the result
// query on a reachable target: one grid read in S_TREAD and S_TCHK, then S_DONE
// blocked target: all width*height cells are scanned, one cell a cycle through the
//   single read port of the grid memory and the shared distance unit
// reset sets width and height to 256; grid contents stay undefined
module nearest_free_grid_cell_top
    import nfgc_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rsp_t                 out_data
);

    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int PROD_W     = COORD_W + DIM_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TREAD = 3'd1;
    localparam logic [2:0] S_TCHK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [DIM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [DIM_W-1:0]   w_reg, w_next, h_reg, h_next;
    logic [COORD_W-1:0] tc_reg, tc_next, tr_reg, tr_next;
    logic [AW-1:0]      tgt_addr_reg, tgt_addr_next;
    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    logic [DIM_W-1:0]   row_reg, row_next, col_reg, col_next;
    logic               p_valid_reg, p_valid_next;
    logic [DIM_W-1:0]   p_row_reg, p_row_next, p_col_reg, p_col_next;
    logic               scanned_reg, scanned_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [PROD_W-1:0]  tgt_prod;
    logic               in_fire;
    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    cell_t              rd_q;
    dist_ctl_t          dctl;
    dist_res_t          dres;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(256);
            grid_height_reg <= DIM_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clamp dimensions to 1 .. maximum
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(grid_width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;

        if (grid_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(grid_height_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = grid_height_reg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign tgt_prod = PROD_W'(in_data.target_row) * PROD_W'(w_eff)
                    + PROD_W'(in_data.target_col);

    // grid storage
    assign mem_we = in_fire && (in_data.req_type == REQ_WRITE)
                 && (32'(in_data.cell_index) < CELL_COUNT);

    nfgc_grid_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_grid_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (AW'(in_data.cell_index)),
        .wr_data (in_data.cell_value),
        .rd_addr (rd_addr),
        .rd_data (rd_q)
    );

    // shared distance unit fed one cell a cycle
    assign dctl.clear  = (state_reg == S_TCHK);
    assign dctl.sample = p_valid_reg && (rd_q == CELL_FREE);
    assign dctl.row    = p_row_reg;
    assign dctl.col    = p_col_reg;

    nfgc_dist_unit u_dist_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dctl),
        .tgt_col (tc_reg),
        .tgt_row (tr_reg),
        .res     (dres)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        tc_next        = tc_reg;
        tr_next        = tr_reg;
        tgt_addr_next  = tgt_addr_reg;
        scan_addr_next = scan_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        p_valid_next   = 1'b0;
        p_row_next     = p_row_reg;
        p_col_next     = p_col_reg;
        scanned_next   = scanned_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_addr        = scan_addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_data.req_type == REQ_QUERY))
                begin
                    tc_next       = in_data.target_col;
                    tr_next       = in_data.target_row;
                    w_next        = w_eff;
                    h_next        = h_eff;
                    tgt_addr_next = AW'(tgt_prod);
                    scanned_next  = 1'b0;
                    if ({1'b0, in_data.target_col} >= w_eff
                        || {1'b0, in_data.target_row} >= h_eff)
                    begin
                        status_next = ST_OUT_OF_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TREAD;
                    end
                end
            end

            S_TREAD:
            begin
                rd_addr    = tgt_addr_reg;
                state_next = S_TCHK;
            end

            S_TCHK:
            begin
                if (rd_q inside {CELL_UNKNOWN, CELL_OCCUPIED})
                begin
                    scan_addr_next = '0;
                    row_next       = '0;
                    col_next       = '0;
                    scanned_next   = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    status_next = ST_REACHABLE;
                    state_next  = S_DONE;
                end
            end

            S_SCAN:
            begin
                p_valid_next   = 1'b1;
                p_row_next     = row_reg;
                p_col_next     = col_reg;
                scan_addr_next = AW'(scan_addr_reg + 1'b1);
                if (col_reg == DIM_W'(w_reg - 1'b1))
                begin
                    col_next = '0;
                    row_next = DIM_W'(row_reg + 1'b1);
                    if (row_reg == DIM_W'(h_reg - 1'b1))
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    col_next = DIM_W'(col_reg + 1'b1);
                end
            end

            S_DRAIN:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (scanned_reg && dres.found)
                    begin
                        out_data_next.result_col = COORD_W'(dres.col);
                        out_data_next.result_row = COORD_W'(dres.row);
                        out_data_next.status     = ST_RELOCATED;
                    end
                    else
                    begin
                        out_data_next.result_col = tc_reg;
                        out_data_next.result_row = tr_reg;
                        out_data_next.status     = scanned_reg ? ST_NO_FREE : status_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            scanned_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            scanned_reg   <= scanned_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        h_reg         <= h_next;
        tc_reg        <= tc_next;
        tr_reg        <= tr_next;
        tgt_addr_reg  <= tgt_addr_next;
        scan_addr_reg <= scan_addr_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        p_row_reg     <= p_row_next;
        p_col_reg     <= p_col_next;
        status_reg    <= status_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/nfgc_grid_mem.sv =====
// ----------------------------------------------------------------------------
// nfgc_grid_mem
// Occupancy grid storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfgc_grid_mem
    import nfgc_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  cell_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output cell_t         rd_data
);

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/nfgc_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nfgc_dist_unit
// Shared squared distance and compare unit that keeps the best free cell.
// ----------------------------------------------------------------------------
module nfgc_dist_unit
    import nfgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dist_ctl_t          ctl,
    input  logic [COORD_W-1:0] tgt_col,
    input  logic [COORD_W-1:0] tgt_row,
    output dist_res_t          res
);

    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;

    logic [DIM_W-1:0]    tr_ext, tc_ext;
    logic [DIM_W-1:0]    drow, dcol;
    logic [2*DIM_W-1:0]  sq_row, sq_col;
    logic [DIST_W-1:0]   cand_dist;

    // absolute differences and squared distance of the candidate
    always_comb
    begin
        tr_ext    = {1'b0, tgt_row};
        tc_ext    = {1'b0, tgt_col};
        drow      = (ctl.row > tr_ext) ? (ctl.row - tr_ext) : (tr_ext - ctl.row);
        dcol      = (ctl.col > tc_ext) ? (ctl.col - tc_ext) : (tc_ext - ctl.col);
        sq_row    = (2*DIM_W)'(drow) * (2*DIM_W)'(drow);
        sq_col    = (2*DIM_W)'(dcol) * (2*DIM_W)'(dcol);
        cand_dist = DIST_W'(sq_row) + DIST_W'(sq_col);
    end

    // strict compare keeps the first cell on a tie
    always_comb
    begin
        found_next = found_reg;
        best_next  = best_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.sample && (!found_reg || cand_dist < best_reg))
        begin
            found_next = 1'b1;
            best_next  = cand_dist;
            row_next   = ctl.row;
            col_next   = ctl.col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
    end

    assign res.found = found_reg;
    assign res.row   = row_reg;
    assign res.col   = col_reg;

endmodule

// ===== sv/nfgc_checker.sv =====
// ----------------------------------------------------------------------------
// nfgc_checker
// Port level checks on the request and result channels of the block.
// ----------------------------------------------------------------------------
module nfgc_checker
    import nfgc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input req_t in_data,
    input logic out_valid,
    input logic out_stall,
    input rsp_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a query transaction makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.req_type == REQ_QUERY |=> in_stall)
        else $error("request taken during a query");

    // a cell write leaves the block ready
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.req_type == REQ_WRITE |=> !in_stall)
        else $error("cell write left the block busy");

    // a new result only comes out of a running query
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a query in progress");

endmodule

bind nearest_free_grid_cell_top nfgc_checker u_nfgc_checker (.*);
